// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and codes for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  // Operation codes carried in the request
  localparam logic [1:0] FUNC_RESERVE = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_ALLOC   = 2'd2;

  // Response status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_CLIPPED = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] page_number;
    logic [12:0] page_count;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] start_page;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator: first-fit page runs over a used-page bitmap in RAM.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// After reset a clearing pass writes zeros to all MAP_WORDS bitmap words (128 at the
// defaults), one per cycle; req_stall stays high meanwhile.
// Reserve/free: the bitmap is walked from word 0 to the last word the range touches,
// one read-modify-write per cycle.
// Allocate: one word examined per cycle until the run is found, then a write pass
// like reserve. The single RAM read port sets this pace.
// One request is in flight at a time; a finished response waits in the output
// register while the next request is already taken.
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_TOTAL = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int MAP_WORDS = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(PAGE_TOTAL + 1);
  localparam int PA        = ((PW > 13) ? PW : 13) + 1;
  localparam int OW        = $clog2(WORD_BITS + 1);
  localparam int SW        = $clog2(2 * WORD_BITS) + 1;
  localparam int RW        = 13;
  localparam int TAIL      = PAGE_TOTAL - (MAP_WORDS - 1) * WORD_BITS;

  localparam logic [WA-1:0]          LAST_WORD = WA'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0]   TAIL_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL);
  localparam logic [2*WORD_BITS-1:0] ONES2     = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RANGE,
    S_DONE
  } state_t;

  state_t state;

  // Request context
  logic [12:0] need;
  logic        rng_set;
  logic [PA-1:0] rng_first;
  logic [PA-1:0] rng_end;
  logic [1:0]  res_status;
  logic [PA-1:0] res_start;

  // Read pipeline: issue side and data-return side
  logic [WA-1:0] clr_word;
  logic [WA-1:0] iss_word;
  logic [PA-1:0] iss_base;
  logic          iss_done;
  logic          pend;
  logic [WA-1:0] proc_word;
  logic [PA-1:0] proc_base;

  // Search state carried between words
  logic [RW-1:0]        run;
  logic [WORD_BITS-1:0] prev_free;

  // RAM port signals
  logic                 ram_wr_en;
  logic [WA-1:0]        ram_wr_addr;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [WORD_BITS-1:0] ram_rd_data;

  bpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (iss_word),
    .rd_data (ram_rd_data)
  );

  // Request decode
  logic [PA-1:0] req_sum;
  logic          req_clip;
  logic [PA-1:0] req_end;
  logic [12:0]   req_need;

  always_comb begin
    req_sum  = PA'(req.page_number) + PA'(req.page_count);
    req_clip = (req.page_count != 13'd0) && (req_sum > PA'(PAGE_TOTAL));
    req_end  = req_clip ? PA'(PAGE_TOTAL) : req_sum;
    req_need = (req.page_count <= 13'd1) ? 13'd1 : req.page_count;
  end

  // Issue-side last word
  logic iss_last;

  always_comb begin
    if (state == S_RANGE) begin
      iss_last = ((iss_base + PA'(WORD_BITS)) >= rng_end) || (iss_word == LAST_WORD);
    end else begin
      iss_last = (iss_word == LAST_WORD);
    end
  end

  // Free bits of the returned word; pages past the store count as used
  logic [WORD_BITS-1:0] free;

  always_comb begin
    free = ~ram_rd_data & ((proc_word == LAST_WORD) ? TAIL_MASK : {WORD_BITS{1'b1}});
  end

  // Short runs (need <= word size): match a run mask against this word and the one before
  logic                   short_need;
  logic [SW-1:0]          need_n;
  logic [2*WORD_BITS-1:0] run_mask;
  logic [2*WORD_BITS-1:0] window;
  logic [WORD_BITS-1:0]   ok;
  logic [OW-1:0]          hit_b;

  always_comb begin
    short_need = (need <= 13'(WORD_BITS));
    need_n     = need[SW-1:0];
    run_mask   = (ONES2 >> (SW'(2 * WORD_BITS) - need_n)) << (SW'(WORD_BITS + 1) - need_n);
    window     = {free, prev_free};
    for (int b = 0; b < WORD_BITS; b++) begin
      ok[b] = (((window >> b) & run_mask) == run_mask);
    end
    hit_b = OW'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (ok[b]) begin
        hit_b = OW'(b);
      end
    end
  end

  // Long runs: free pages at the bottom extend the run carried from below
  logic [OW-1:0] tz;
  logic [OW-1:0] lz;
  logic [RW:0]   run_sum;

  always_comb begin
    tz = OW'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!free[b]) begin
        tz = OW'(b);
      end
    end
    lz = OW'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!free[b]) begin
        lz = OW'(WORD_BITS - 1 - b);
      end
    end
    run_sum = (RW + 1)'(run) + (RW + 1)'(tz);
  end

  logic          hit;
  logic [PA-1:0] hit_start;
  logic [RW-1:0] run_next;

  always_comb begin
    if (short_need) begin
      hit       = |ok;
      hit_start = proc_base + PA'(hit_b) + PA'(1) - PA'(need);
    end else begin
      hit       = (run_sum >= (RW + 1)'(need));
      hit_start = proc_base - PA'(run);
    end
    run_next = (&free) ? (run + RW'(WORD_BITS)) : RW'(lz);
  end

  // Range mask of the returned word: bits lo_c up to, not including, hi_c
  logic [PA-1:0]        lo_d;
  logic [PA-1:0]        hi_d;
  logic [OW-1:0]        lo_c;
  logic [OW-1:0]        hi_c;
  logic [WORD_BITS-1:0] wmask;

  always_comb begin
    lo_d = rng_first - proc_base;
    hi_d = rng_end - proc_base;
    if (rng_first <= proc_base) begin
      lo_c = '0;
    end else if (lo_d > PA'(WORD_BITS)) begin
      lo_c = OW'(WORD_BITS);
    end else begin
      lo_c = lo_d[OW-1:0];
    end
    if (rng_end <= proc_base) begin
      hi_c = '0;
    end else if (hi_d > PA'(WORD_BITS)) begin
      hi_c = OW'(WORD_BITS);
    end else begin
      hi_c = hi_d[OW-1:0];
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      wmask[b] = (OW'(b) >= lo_c) && (OW'(b) < hi_c);
    end
  end

  // RAM control
  always_comb begin
    ram_rd_en   = ((state == S_SCAN) || (state == S_RANGE)) && !iss_done;
    ram_wr_en   = (state == S_CLEAR) || ((state == S_RANGE) && pend);
    ram_wr_addr = (state == S_CLEAR) ? clr_word : proc_word;
    if (state == S_CLEAR) begin
      ram_wr_data = '0;
    end else if (rng_set) begin
      ram_wr_data = ram_rd_data | wmask;
    end else begin
      ram_wr_data = ram_rd_data & ~wmask;
    end
  end

  assign req_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_word  <= '0;
      iss_done  <= 1'b0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_word == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            clr_word <= clr_word + WA'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            iss_word   <= '0;
            iss_base   <= '0;
            iss_done   <= 1'b0;
            pend       <= 1'b0;
            run        <= '0;
            prev_free  <= '0;
            res_start  <= '0;
            need       <= req_need;
            rng_first  <= PA'(req.page_number);
            rng_end    <= req_end;
            // allocate marks its run as used, like reserve
            rng_set    <= (req.func != FUNC_FREE);
            if ((req.func == FUNC_RESERVE) || (req.func == FUNC_FREE)) begin
              res_status <= req_clip ? STATUS_CLIPPED : STATUS_OK;
              state      <= (req_end > PA'(req.page_number)) ? S_RANGE : S_DONE;
            end else if (req.func == FUNC_ALLOC) begin
              if (PA'(req_need) > PA'(PAGE_TOTAL)) begin
                res_status <= STATUS_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= STATUS_OK;
                state      <= S_SCAN;
              end
            end else begin
              res_status <= STATUS_OK;
              state      <= S_DONE;
            end
          end
        end
        S_SCAN, S_RANGE: begin
          if (pend && (state == S_SCAN) && hit) begin
            // run found: restart the walk to mark it
            rng_first <= hit_start;
            rng_end   <= hit_start + PA'(need);
            res_start <= hit_start;
            iss_word  <= '0;
            iss_base  <= '0;
            iss_done  <= 1'b0;
            pend      <= 1'b0;
            state     <= S_RANGE;
          end else begin
            // issue the next read
            if (!iss_done) begin
              pend      <= 1'b1;
              proc_word <= iss_word;
              proc_base <= iss_base;
              iss_word  <= iss_word + WA'(1);
              iss_base  <= iss_base + PA'(WORD_BITS);
              iss_done  <= iss_last;
            end else begin
              pend <= 1'b0;
            end
            // consume the returned word
            if (pend) begin
              if (state == S_SCAN) begin
                if (iss_done) begin
                  res_status <= STATUS_FULL;
                  res_start  <= '0;
                  state      <= S_DONE;
                end else begin
                  run       <= run_next;
                  prev_free <= free;
                end
              end else if (iss_done) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status     <= res_status;
            rsp.start_page <= res_start[11:0];
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
